// ===== hw/rtl/thds_pkg.sv =====
// ----------------------------------------------------------------------------
// thds_pkg
// Shared types, register codes and helpers of the strobe dwell controller.
// ----------------------------------------------------------------------------
package thds_pkg;

	localparam int MAX_SEGMENTS = 4;
	localparam int DOT_W        = 11;

	typedef enum logic [3:0] {
		REG_DENSITY  = 4'd0,
		REG_BASE     = 4'd1,
		REG_MAX      = 4'd2,
		REG_SAG      = 4'd3
	} reg_idx_e;

	localparam logic [4:0] DENSITY_MAX = 5'd16;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] heat_scale;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  segment;
		logic        fire;
		logic [9:0]  dwell_us;
		logic [11:0] line_total_us;
		logic        last_result;
	} out_item_t;

	typedef struct packed {
		logic [4:0] density;
		logic [9:0] base_dwell_us;
		logic [9:0] max_dwell_us;
		logic [9:0] sag_full_us;
	} cfg_t;

	typedef struct packed {
		logic [MAX_SEGMENTS-1:0][DOT_W-1:0] dots;
		logic [15:0]                        heat_scale;
	} line_desc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_CLAMP,
		ST_SAG,
		ST_DIV,
		ST_EMIT
	} back_state_e;

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, v[i]};
		end
		return n;
	endfunction

endpackage

// ===== hw/rtl/thds_front.sv =====
// ----------------------------------------------------------------------------
// thds_front
// Counts set dots per head segment and hands a line descriptor downstream.
// ----------------------------------------------------------------------------
module thds_front #(
	parameter int HALF_BYTES = 78,
	parameter int SEGMENTS   = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  thds_pkg::in_item_t   item,
	output logic                 desc_push,
	output thds_pkg::line_desc_t desc
);
	import thds_pkg::*;

	localparam int SW = $clog2(SEGMENTS + 1);

	logic [SW-1:0] seg_q;
	logic [7:0]    pos_q;
	logic [MAX_SEGMENTS-1:0][DOT_W-1:0] count_q;
	logic [MAX_SEGMENTS-1:0][DOT_W-1:0] count_next;
	logic          in_head;
	logic [3:0]    ones;

	assign in_head = int'(seg_q) < SEGMENTS;
	assign ones    = popcount8(item.data_byte);

	always_comb begin
		count_next = count_q;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			if (in_head && int'(seg_q) == i) begin
				count_next[i] = count_q[i] + {{(DOT_W-4){1'b0}}, ones};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= '0;
			pos_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (item.last_byte) begin
				seg_q   <= '0;
				pos_q   <= '0;
				count_q <= '0;
			end else begin
				count_q <= count_next;
				if (in_head) begin
					if (pos_q == 8'(HALF_BYTES - 1)) begin
						pos_q <= '0;
						seg_q <= seg_q + SW'(1);
					end else begin
						pos_q <= pos_q + 8'd1;
					end
				end
			end
		end
	end

	assign desc_push       = accept && item.last_byte;
	assign desc.dots       = count_next;
	assign desc.heat_scale = item.heat_scale;

endmodule

// ===== hw/rtl/thds_queue.sv =====
// ----------------------------------------------------------------------------
// thds_queue
// Two-entry queue of line descriptors between the front and back parts.
// ----------------------------------------------------------------------------
module thds_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  thds_pkg::line_desc_t wr_data,
	input  logic                 rd_en,
	output thds_pkg::line_desc_t rd_data,
	output logic                 full,
	output logic                 avail
);
	import thds_pkg::*;

	line_desc_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= ~wr_q;
			end
			if (rd_en) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	assign rd_data = mem_q[rd_q];
	assign full    = cnt_q == 2'd2;
	assign avail   = cnt_q != 2'd0;

endmodule

// ===== hw/rtl/thds_back.sv =====
// ----------------------------------------------------------------------------
// thds_back
// Computes each segment's dwell for a queued line and drives the result slot.
// ----------------------------------------------------------------------------
module thds_back #(
	parameter int HALF_BYTES = 78,
	parameter int SEGMENTS   = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  thds_pkg::cfg_t       cfg,
	input  logic                 desc_avail,
	input  thds_pkg::line_desc_t desc,
	output logic                 desc_pop,
	output logic                 empty,
	input  logic                 pop,
	output thds_pkg::out_item_t  result
);
	import thds_pkg::*;

	// The sag product is divided by eight times HALF_BYTES: a shift by three,
	// then a multiplication by the rounded-up reciprocal of HALF_BYTES.
	localparam int RECIP_SHIFT = 26;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + HALF_BYTES - 1) / HALF_BYTES;

	back_state_e state_q;
	back_state_e state_next;

	logic [14:0] prod1_q;
	logic [26:0] prod2_q;
	logic [9:0]  dbase_q;
	logic [1:0]  seg_q;
	logic [DOT_W-1:0] n_q;
	logic        fire_q;
	logic [20:0] rem_q;
	logic [9:0]  quo_q;
	logic [11:0] total_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        slot_free;
	logic        load_out;
	logic        seg_last;
	logic [18:0] scaled;
	logic [44:0] sag_prod;
	logic [10:0] sum;
	logic [9:0]  dwell;
	logic [11:0] total_next;

	assign slot_free = !out_valid_q || pop;
	assign seg_last  = seg_q == 2'(SEGMENTS - 1);
	assign scaled    = prod2_q[26:8];
	assign sag_prod  = {27'b0, rem_q[20:3]} * {18'b0, 27'(RECIP)};
	assign sum       = {1'b0, dbase_q} + {1'b0, quo_q};

	always_comb begin
		if (!fire_q) begin
			dwell = '0;
		end else if (dbase_q == '0 || n_q == '0) begin
			dwell = dbase_q;
		end else if (sum > {1'b0, cfg.max_dwell_us}) begin
			dwell = cfg.max_dwell_us;
		end else begin
			dwell = sum[9:0];
		end
		total_next = total_q + {2'b00, dwell};
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:  if (desc_avail) state_next = ST_MUL1;
			ST_MUL1:  state_next = ST_MUL2;
			ST_MUL2:  state_next = ST_CLAMP;
			ST_CLAMP: state_next = ST_SAG;
			ST_SAG:   state_next = ST_DIV;
			ST_DIV:   state_next = ST_EMIT;
			ST_EMIT: begin
				if (slot_free) state_next = seg_last ? ST_IDLE : ST_SAG;
			end
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		load_out = 1'b0;
		desc_pop = 1'b0;
		unique case (state_q)
			ST_EMIT: begin
				load_out = slot_free;
				desc_pop = slot_free && seg_last;
			end
			default: begin
				load_out = 1'b0;
				desc_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_MUL1: prod1_q <= {5'b0, cfg.base_dwell_us} * {10'b0, cfg.density};
			ST_MUL2: prod2_q <= {15'b0, prod1_q[14:3]} * {11'b0, desc.heat_scale};
			ST_CLAMP: begin
				dbase_q <= (scaled > {9'b0, cfg.max_dwell_us}) ?
					cfg.max_dwell_us : scaled[9:0];
				seg_q   <= '0;
				total_q <= '0;
			end
			ST_SAG: begin
				n_q    <= desc.dots[seg_q];
				fire_q <= cfg.density != '0 && !(SEGMENTS == 2 && desc.dots[seg_q] == '0);
				rem_q  <= {11'b0, cfg.sag_full_us} * {10'b0, desc.dots[seg_q]};
			end
			ST_DIV: begin
				quo_q <= sag_prod[RECIP_SHIFT +: 10];
			end
			ST_EMIT: begin
				if (load_out) begin
					out_q.segment       <= seg_q;
					out_q.fire          <= fire_q;
					out_q.dwell_us      <= dwell;
					out_q.line_total_us <= total_next;
					out_q.last_result   <= seg_last;
					total_q             <= total_next;
					seg_q               <= seg_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

// ===== hw/rtl/thermal_head_strobe_dwell_core.sv =====
// ----------------------------------------------------------------------------
// thermal_head_strobe_dwell_core
// Counts dots per head segment over a line and issues one strobe dwell per
// segment after the line's last byte arrives.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     push / full          item   (thds_pkg::in_item_t)
// result    pop / empty          result (thds_pkg::out_item_t)
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Line bytes are taken one per cycle while full is low; full rises only when
// two finished lines wait in the descriptor queue. Each line passes through
// scaling in the back end and then, per segment, the sag product, its
// reciprocal division and the result load. Reset is asynchronous; all counts
// and queues start empty, registers at their documented defaults. A stalled
// result holds the back end, and the queue then fills and stops the input.
// ----------------------------------------------------------------------------
module thermal_head_strobe_dwell_core #(
	parameter int HALF_BYTES = 78,
	parameter int SEGMENTS   = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  thds_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output thds_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import thds_pkg::*;

	cfg_t       cfg_q;
	logic       accept;
	logic       desc_push;
	logic       desc_pop;
	logic       desc_avail;
	line_desc_t desc_in;
	line_desc_t desc_out;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.density       <= 5'd8;
			cfg_q.base_dwell_us <= 10'd270;
			cfg_q.max_dwell_us  <= 10'd410;
			cfg_q.sag_full_us   <= 10'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DENSITY: begin
					if (cfg_data[4:0] <= DENSITY_MAX) cfg_q.density <= cfg_data[4:0];
				end
				REG_BASE: cfg_q.base_dwell_us <= cfg_data[9:0];
				REG_MAX:  cfg_q.max_dwell_us  <= cfg_data[9:0];
				REG_SAG:  cfg_q.sag_full_us   <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	thds_front #(
		.HALF_BYTES(HALF_BYTES),
		.SEGMENTS  (SEGMENTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.desc_push(desc_push),
		.desc     (desc_in)
	);

	thds_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (desc_push),
		.wr_data(desc_in),
		.rd_en  (desc_pop),
		.rd_data(desc_out),
		.full   (full),
		.avail  (desc_avail)
	);

	thds_back #(
		.HALF_BYTES(HALF_BYTES),
		.SEGMENTS  (SEGMENTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.desc_avail(desc_avail),
		.desc      (desc_out),
		.desc_pop  (desc_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== hw/rtl/thds_checker.sv =====
// ----------------------------------------------------------------------------
// thds_checker
// Port-level checks on the result stream of the strobe dwell controller.
// ----------------------------------------------------------------------------
module thds_checker #(
	parameter int SEGMENTS = 2
) (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input thds_pkg::out_item_t result
);
	import thds_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("Waiting result transaction changed before it was taken.");

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> int'(result.segment) < SEGMENTS)
		else $error("Result segment index beyond the head.");

	a_last_seg: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.last_result == (int'(result.segment) == SEGMENTS - 1))
		else $error("Last result flag does not match the final segment.");

	a_nofire: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.fire |-> result.dwell_us == '0)
		else $error("Skipped segment carries a nonzero dwell.");

endmodule

bind thermal_head_strobe_dwell_core thds_checker #(.SEGMENTS(SEGMENTS)) u_thds_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.empty (empty),
	.pop   (pop),
	.result(result)
);
